### hw/rtl/chva_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and constants of the circle Hough vote accumulator.
package chva_pkg;

   localparam int AccWidthDef  = 128;
   localparam int AccHeightDef = 128;

   localparam int CoordW   = 14;
   localparam int OffW     = 13;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 12;

   localparam logic [CsrIdxW-1:0] CSR_RADIUS     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_BOX_LEFT   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_BOX_TOP    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_BOX_WIDTH  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_BOX_HEIGHT = 3'd4;

   localparam logic [6:0]  RADIUS_RST     = 7'd5;
   localparam logic [11:0] BOX_LEFT_RST   = 12'd0;
   localparam logic [11:0] BOX_TOP_RST    = 12'd0;
   localparam logic [7:0]  BOX_WIDTH_RST  = 8'd128;
   localparam logic [7:0]  BOX_HEIGHT_RST = 8'd128;

   localparam logic KIND_CLEAR = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [11:0] point_x;
      logic [11:0] point_y;
   } req_type;

   typedef struct packed {
      logic [7:0] best_count;
      logic [6:0] best_x;
      logic [6:0] best_y;
   } rsp_type;

   typedef struct packed {
      logic                   kind;
      logic signed [OffW-1:0] cx;
      logic signed [OffW-1:0] cy;
   } cmd_type;

   typedef struct packed {
      logic [6:0] radius;
      logic [7:0] box_width;
      logic [7:0] box_height;
   } geom_type;

endpackage

### hw/rtl/circle_hough_vote_accumulator_core.sv
`timescale 1ns / 1ps
// Top level of the circle Hough vote accumulator: registers and the front, queue and engine.
//
// Input channel req_*: one item per valid/ready handshake. kind clear zeroes the vote
// store and the best vote; kind point casts one vote on each pixel, inside box and store,
// of a midpoint circle of the configured radius around the point, relative to box origin.
// Result channel rsp_*: exactly one item per input item, in order, carrying the best
// count since the last clear and its box position.
// Configuration csr_*: write enable, register index and data; write only while idle.
// Timing: the engine handles one vote pixel per cycle through a read-modify-write
// pipeline on a vote store with one read and one write port. A point item with N circle
// pixels (N = 4 + 8 * midpoint steps, about 4 + 5.7 * radius) is walked pixel by pixel;
// the vote pipeline then drains, the result is loaded and the engine takes the next item.
// A clear item sweeps the store, one entry per cycle, and then gives its result.
// Reset: the store is swept to zero; req_ready stays low until the sweep ends.
// Configuration writes are taken during the sweep.
// Stall: a result waits in the output register while rsp_ready is low; the front and
// a two-entry queue keep taking items until they fill, then req_ready drops.
module circle_hough_vote_accumulator_core #(
   parameter int ACC_WIDTH  = chva_pkg::AccWidthDef,
   parameter int ACC_HEIGHT = chva_pkg::AccHeightDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  chva_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output chva_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [chva_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [chva_pkg::CsrDataW-1:0]  csr_wdata
);
   import chva_pkg::*;

   logic [6:0]  radius_ff, radius_in;
   logic [11:0] box_left_ff, box_left_in;
   logic [11:0] box_top_ff, box_top_in;
   logic [7:0]  box_width_ff, box_width_in;
   logic [7:0]  box_height_ff, box_height_in;

   geom_type geom;
   logic     init_done;
   logic     push_valid, push_ready;
   cmd_type  push_cmd;
   logic     pop_valid, pop_ready;
   cmd_type  pop_cmd;

   always_comb begin
      radius_in     = radius_ff;
      box_left_in   = box_left_ff;
      box_top_in    = box_top_ff;
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:     radius_in     = csr_wdata[6:0];
            CSR_BOX_LEFT:   box_left_in   = csr_wdata[11:0];
            CSR_BOX_TOP:    box_top_in    = csr_wdata[11:0];
            CSR_BOX_WIDTH:  box_width_in  = csr_wdata[7:0];
            CSR_BOX_HEIGHT: box_height_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RST;
         box_left_ff   <= BOX_LEFT_RST;
         box_top_ff    <= BOX_TOP_RST;
         box_width_ff  <= BOX_WIDTH_RST;
         box_height_ff <= BOX_HEIGHT_RST;
      end else begin
         radius_ff     <= radius_in;
         box_left_ff   <= box_left_in;
         box_top_ff    <= box_top_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

   always_comb begin
      geom.radius     = radius_ff;
      geom.box_width  = box_width_ff;
      geom.box_height = box_height_ff;
   end

   chva_front u_front (
      .clock      (clock),
      .reset      (reset),
      .init_done  (init_done),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .box_left   (box_left_ff),
      .box_top    (box_top_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   chva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   chva_back #(
      .ACC_WIDTH  (ACC_WIDTH),
      .ACC_HEIGHT (ACC_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .init_done (init_done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/chva_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, classifies them and moves them into box coordinates.
module chva_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              init_done,
   input  logic              req_valid,
   output logic              req_ready,
   input  chva_pkg::req_type req_data,
   input  logic [11:0]       box_left,
   input  logic [11:0]       box_top,
   output logic              push_valid,
   input  logic              push_ready,
   output chva_pkg::cmd_type push_cmd
);
   import chva_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;

   assign req_ready  = init_done && (!hold_valid_ff || push_ready);
   assign accept     = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in    = 1'b1;
         hold_cmd_in.kind = req_data.kind;
         if (req_data.kind == KIND_POINT) begin
            hold_cmd_in.cx = $signed({1'b0, req_data.point_x}) - $signed({1'b0, box_left});
            hold_cmd_in.cy = $signed({1'b0, req_data.point_y}) - $signed({1'b0, box_top});
         end else begin
            hold_cmd_in.cx = '0;
            hold_cmd_in.cy = '0;
         end
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

### hw/rtl/chva_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the voting engine.
module chva_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  chva_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output chva_pkg::cmd_type pop_cmd
);
   import chva_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/chva_back.sv
`timescale 1ns / 1ps
// Voting engine: clearing sweep, midpoint circle walk, vote store update and best tracking.
module chva_back #(
   parameter int ACC_WIDTH  = chva_pkg::AccWidthDef,
   parameter int ACC_HEIGHT = chva_pkg::AccHeightDef
) (
   input  logic               clock,
   input  logic               reset,
   input  chva_pkg::geom_type geom,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  chva_pkg::cmd_type  pop_cmd,
   output logic               init_done,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output chva_pkg::rsp_type  rsp_data
);
   import chva_pkg::*;

   localparam int XW    = $clog2(ACC_WIDTH);
   localparam int YW    = $clog2(ACC_HEIGHT);
   localparam int Depth = ACC_WIDTH * ACC_HEIGHT;
   localparam int AW    = $clog2(Depth);
   localparam logic [AW-1:0]     LastAddr = AW'(Depth - 1);
   localparam logic [AW-1:0]     RowStep  = AW'(ACC_WIDTH);
   localparam logic [CoordW-1:0] WidthLim  = CoordW'(ACC_WIDTH);
   localparam logic [CoordW-1:0] HeightLim = CoordW'(ACC_HEIGHT);

   typedef enum logic [4:0] {
      ST_SWEEP  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_CIRCLE = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_RESULT = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic           reply_ff, reply_in;
   logic           init_done_ff, init_done_in;
   logic [AW-1:0]  sweep_ff, sweep_in;

   logic signed [OffW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [6:0]             dx_ff, dx_in, dy_ff, dy_in;
   logic signed [11:0]     err_ff, err_in;
   logic signed [10:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic [2:0]             phase_ff, phase_in;
   logic                   axis_ff, axis_in;

   logic              p_valid_ff, p_valid_in;
   logic [CoordW-1:0] p_x_ff, p_x_in, p_y_ff, p_y_in;

   logic          b_valid_ff, b_valid_in;
   logic [AW-1:0] b_addr_ff, b_addr_in;
   logic [XW-1:0] b_x_ff, b_x_in;
   logic [YW-1:0] b_y_ff, b_y_in;
   logic          fwd_ff, fwd_in;
   logic [7:0]    wval_ff, wval_in;
   logic [7:0]    rdata_ff;

   logic [7:0]    peak_count_ff, peak_count_in;
   logic [XW-1:0] peak_x_ff, peak_x_in;
   logic [YW-1:0] peak_y_ff, peak_y_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0] vote_mem [Depth];

   logic [2:0]         code;
   logic [6:0]         off_a, off_b;
   logic [CoordW-1:0]  off_a_ext, off_b_ext, cx_ext, cy_ext, gen_x, gen_y;
   logic               group_last, more;
   logic [6:0]         dy_step;
   logic signed [10:0] sy_step, sx_step;
   logic signed [11:0] err_mid, err_step;

   logic          a_valid;
   logic [AW-1:0] a_addr;
   logic [7:0]    cur, nv;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // circle pixel generator
   always_comb begin
      code      = axis_ff ? {phase_ff[1], !phase_ff[1] && phase_ff[0], phase_ff[1] && phase_ff[0]}
                          : phase_ff;
      off_a     = code[2] ? dy_ff : dx_ff;
      off_b     = code[2] ? dx_ff : dy_ff;
      off_a_ext = {{(CoordW-7){1'b0}}, off_a};
      off_b_ext = {{(CoordW-7){1'b0}}, off_b};
      cx_ext    = {cx_ff[OffW-1], cx_ff};
      cy_ext    = {cy_ff[OffW-1], cy_ff};
      gen_x     = code[0] ? cx_ext - off_a_ext : cx_ext + off_a_ext;
      gen_y     = code[1] ? cy_ext - off_b_ext : cy_ext + off_b_ext;
      group_last = axis_ff ? (phase_ff == 3'd3) : (phase_ff == 3'd7);
      more      = (dx_ff < dy_ff);
      if (!err_ff[11]) begin
         dy_step = dy_ff - 7'd1;
         sy_step = sy_ff + 11'sd2;
         err_mid = err_ff + {sy_step[10], sy_step};
      end else begin
         dy_step = dy_ff;
         sy_step = sy_ff;
         err_mid = err_ff;
      end
      sx_step  = sx_ff + 11'sd2;
      err_step = err_mid + {sx_step[10], sx_step};
   end

   // box check and address
   always_comb begin
      a_valid = p_valid_ff && !p_x_ff[CoordW-1] && !p_y_ff[CoordW-1]
                && (p_x_ff < {{(CoordW-8){1'b0}}, geom.box_width}) && (p_x_ff < WidthLim)
                && (p_y_ff < {{(CoordW-8){1'b0}}, geom.box_height}) && (p_y_ff < HeightLim);
      a_addr  = AW'(p_y_ff[YW-1:0]) * RowStep + AW'(p_x_ff[XW-1:0]);
   end

   // read-modify-write with forwarding of the previous write
   assign cur       = fwd_ff ? wval_ff : rdata_ff;
   assign nv        = cur + 8'd1;
   assign mem_we    = (state_ff == ST_SWEEP) || b_valid_ff;
   assign mem_waddr = (state_ff == ST_SWEEP) ? sweep_ff : b_addr_ff;
   assign mem_wdata = (state_ff == ST_SWEEP) ? 8'd0 : nv;

   assign pop_ready = (state_ff == ST_IDLE);
   assign init_done = init_done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      reply_in      = reply_ff;
      init_done_in  = init_done_ff;
      sweep_in      = sweep_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      err_in        = err_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      phase_in      = phase_ff;
      axis_in       = axis_ff;
      p_valid_in    = 1'b0;
      p_x_in        = gen_x;
      p_y_in        = gen_y;
      b_valid_in    = a_valid;
      b_addr_in     = a_addr;
      b_x_in        = p_x_ff[XW-1:0];
      b_y_in        = p_y_ff[YW-1:0];
      fwd_in        = a_valid && b_valid_ff && (a_addr == b_addr_ff);
      wval_in       = nv;
      peak_count_in = peak_count_ff;
      peak_x_in     = peak_x_ff;
      peak_y_in     = peak_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (b_valid_ff && (nv > peak_count_ff)) begin
         peak_count_in = nv;
         peak_x_in     = b_x_ff;
         peak_y_in     = b_y_ff;
      end

      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == LastAddr) begin
               init_done_in = 1'b1;
               state_in     = reply_ff ? ST_RESULT : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_cmd.kind == KIND_CLEAR) begin
                  state_in      = ST_SWEEP;
                  reply_in      = 1'b1;
                  sweep_in      = '0;
                  peak_count_in = '0;
                  peak_x_in     = '0;
                  peak_y_in     = '0;
               end else begin
                  state_in = ST_CIRCLE;
                  cx_in    = pop_cmd.cx;
                  cy_in    = pop_cmd.cy;
                  dx_in    = 7'd0;
                  dy_in    = geom.radius;
                  err_in   = 12'sd1 - $signed({5'b0, geom.radius});
                  sx_in    = 11'sd1;
                  sy_in    = -$signed({3'b0, geom.radius, 1'b0});
                  phase_in = 3'd0;
                  axis_in  = 1'b1;
               end
            end
         end
         ST_CIRCLE: begin
            p_valid_in = 1'b1;
            if (group_last) begin
               if (more) begin
                  dx_in    = dx_ff + 7'd1;
                  dy_in    = dy_step;
                  sx_in    = sx_step;
                  sy_in    = sy_step;
                  err_in   = err_step;
                  phase_in = 3'd0;
                  axis_in  = 1'b0;
               end else begin
                  state_in = ST_DRAIN;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (!p_valid_ff && !b_valid_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.best_count = peak_count_ff;
               rsp_data_in.best_x     = 7'(peak_x_ff);
               rsp_data_in.best_y     = 7'(peak_y_ff);
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         reply_ff      <= 1'b0;
         init_done_ff  <= 1'b0;
         sweep_ff      <= '0;
         p_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         peak_count_ff <= '0;
         peak_x_ff     <= '0;
         peak_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         reply_ff      <= reply_in;
         init_done_ff  <= init_done_in;
         sweep_ff      <= sweep_in;
         p_valid_ff    <= p_valid_in;
         b_valid_ff    <= b_valid_in;
         peak_count_ff <= peak_count_in;
         peak_x_ff     <= peak_x_in;
         peak_y_ff     <= peak_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      err_ff      <= err_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      phase_ff    <= phase_in;
      axis_ff     <= axis_in;
      p_x_ff      <= p_x_in;
      p_y_ff      <= p_y_in;
      b_addr_ff   <= b_addr_in;
      b_x_ff      <= b_x_in;
      b_y_ff      <= b_y_in;
      fwd_ff      <= fwd_in;
      wval_ff     <= wval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vote_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= vote_mem[a_addr];
   end

`ifndef SYNTH
   a_pixel_only_from_walk: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && p_valid_ff |-> $past(state_ff == ST_CIRCLE))
      else $error("pixel issued outside circle walk");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !p_valid_ff && !b_valid_ff)
      else $error("vote pipeline busy while idle");

   a_result_from_result_state: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result loaded outside result state");

   a_peak_drops_only_on_clear: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (peak_count_ff < $past(peak_count_ff))
      |-> $past(state_ff == ST_IDLE) && (state_ff == ST_SWEEP))
      else $error("best count fell without a clear");

   a_forward_needs_prior_write: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && b_valid_ff && fwd_ff |-> $past(b_valid_ff))
      else $error("forwarding without a preceding write");
`endif

endmodule
